### src/nat_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nat_pkg: shared types and constants for the name-to-id table
// Sizes, cell token and write request types, state codes and name trimming.
// ----------------------------------------------------------------------------
package nat_pkg;

  localparam int ENTRIES   = 16;
  localparam int ID_BITS   = 8;
  localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int NAME_LO_W = 64;
  localparam int NAME_HI_W = 24;
  localparam int NAME_BYTES = (NAME_LO_W + NAME_HI_W) / 8;
  localparam int TID_W     = 8;

  // request modes
  localparam logic MODE_REGISTER = 1'b0;
  localparam logic MODE_LOOKUP   = 1'b1;

  typedef logic [ID_BITS-1:0] id_t;
  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [TID_W-1:0]   tid_t;

  typedef struct packed {
    logic [NAME_HI_W-1:0] hi;
    logic [NAME_LO_W-1:0] lo;
  } key_t;

  // search token handed from cell to cell
  typedef struct packed {
    logic act;
    logic hit;
    idx_t idx;
    id_t  id;
  } tok_t;

  // write request broadcast to the cells
  typedef struct packed {
    logic key_en;
    logic id_en;
    id_t  id;
  } wr_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FINISH
  } state_t;

  // Zero every byte from the first zero byte of the name onward.
  function automatic key_t trim_key(input logic [NAME_LO_W-1:0] lo,
                                    input logic [NAME_HI_W-1:0] hi);
    logic [NAME_LO_W+NAME_HI_W-1:0] raw;
    logic [NAME_LO_W+NAME_HI_W-1:0] res;
    logic                           keep;
    raw  = {hi, lo};
    res  = '0;
    keep = 1'b1;
    for (int b = 0; b < NAME_BYTES; b++) begin
      keep = keep & (raw[8*b +: 8] != 8'h00);
      res[8*b +: 8] = keep ? raw[8*b +: 8] : 8'h00;
    end
    return key_t'(res);
  endfunction

endpackage

### src/nat_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nat_cell: one table entry of the name-to-id chain
// Holds a key, an id and a valid bit; compares the key against the request
// when the search token passes and hands the token on to the next cell.
// ----------------------------------------------------------------------------
module nat_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  nat_pkg::idx_t my_idx,
  input  nat_pkg::key_t key_i,
  input  nat_pkg::tok_t tok_i,
  output nat_pkg::tok_t tok_o,
  input  logic          wr_sel,
  input  nat_pkg::wr_t  wr_i
);

  nat_pkg::key_t key_r;
  nat_pkg::id_t  id_r;
  logic          valid_r;
  logic          valid_nxt;
  logic          act_r;
  logic          act_nxt;
  logic          hit_r;
  logic          hit_nxt;
  nat_pkg::idx_t idx_r;
  nat_pkg::idx_t idx_nxt;
  nat_pkg::id_t  tid_r;
  nat_pkg::id_t  tid_nxt;
  logic          match;

  // compare the broadcast key with this entry
  assign match = valid_r && (key_r == key_i);

  // merge this entry's result into the passing token
  always_comb begin
    act_nxt = tok_i.act;
    hit_nxt = tok_i.hit | match;
    idx_nxt = tok_i.hit ? tok_i.idx : my_idx;
    tid_nxt = tok_i.hit ? tok_i.id  : id_r;
  end

  always_comb begin
    valid_nxt = valid_r;
    if (wr_sel && wr_i.key_en) begin
      valid_nxt = 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r   <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      act_r   <= act_nxt;
      valid_r <= valid_nxt;
    end
  end

  // token payload
  always_ff @(posedge clk) begin
    if (tok_i.act) begin
      hit_r <= hit_nxt;
      idx_r <= idx_nxt;
      tid_r <= tid_nxt;
    end
  end

  // entry contents
  always_ff @(posedge clk) begin
    if (wr_sel && wr_i.key_en) begin
      key_r <= key_i;
    end
    if (wr_sel && wr_i.id_en) begin
      id_r <= wr_i.id;
    end
  end

  assign tok_o = '{act: act_r, hit: hit_r, idx: idx_r, id: tid_r};

endmodule

### src/name_to_id_assoc_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// name_to_id_assoc_table: associative name-to-id table, round-robin refill
// Registers or looks up names of up to 11 bytes against a row of entry cells.
// ----------------------------------------------------------------------------
// One request is in work at a time. After acceptance a start register
// launches the search token, which walks the row of ENTRIES cells one cell
// per clock; the token leaving the last cell is captured into the result
// registers, and the finish state writes the table on a register request
// and loads the output register, waiting while a held result is stalled.
// A new request is taken only once the table is idle again. A register
// request overwrites the id on a hit, or fills the next round-robin slot on
// a miss, evicting the oldest entry once the table is full; its result has
// found set if the name was present, with found_id zero. A lookup returns
// the stored id on a hit. Name bytes after the first zero byte are ignored.
// ----------------------------------------------------------------------------
module name_to_id_assoc_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_mode,
  input  logic [63:0] in_name_low,
  input  logic [23:0] in_name_high,
  input  logic [7:0]  in_task_id,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_found,
  output logic [7:0]  out_found_id
);

  nat_pkg::state_t state_r;
  nat_pkg::state_t state_nxt;
  logic            in_acc;
  logic            out_free;
  logic            fin_go;
  logic            do_reg;

  nat_pkg::key_t   key_r;
  logic            mode_r;
  nat_pkg::id_t    tid_r;
  logic            start_r;

  logic            res_hit_r;
  nat_pkg::idx_t   res_idx_r;
  nat_pkg::id_t    res_id_r;

  nat_pkg::idx_t   next_slot_r;
  nat_pkg::idx_t   next_slot_nxt;
  nat_pkg::idx_t   wr_tgt;
  nat_pkg::wr_t    wr;
  logic [nat_pkg::ENTRIES-1:0] wr_sel;

  logic            out_valid_r;
  logic            out_valid_nxt;
  logic            out_found_r;
  nat_pkg::tid_t   out_found_id_r;

  nat_pkg::tok_t   tok [nat_pkg::ENTRIES+1];

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      nat_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = nat_pkg::ST_WALK;
        end
      end
      nat_pkg::ST_WALK: begin
        if (tok[nat_pkg::ENTRIES].act) begin
          state_nxt = nat_pkg::ST_FINISH;
        end
      end
      nat_pkg::ST_FINISH: begin
        if (out_free) begin
          state_nxt = nat_pkg::ST_IDLE;
        end
      end
      default: state_nxt = nat_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall = 1'b1;
    fin_go   = 1'b0;
    unique case (state_r)
      nat_pkg::ST_IDLE:   in_stall = 1'b0;
      nat_pkg::ST_WALK:   in_stall = 1'b1;
      nat_pkg::ST_FINISH: fin_go   = out_free;
      default:            in_stall = 1'b1;
    endcase
  end

  // write back: id on a hit, whole entry at the round-robin slot on a miss
  assign do_reg = fin_go && (mode_r == nat_pkg::MODE_REGISTER);
  assign wr_tgt = res_hit_r ? res_idx_r : next_slot_r;
  assign wr     = '{key_en: !res_hit_r, id_en: 1'b1, id: tid_r};

  always_comb begin
    next_slot_nxt = next_slot_r;
    if (do_reg && !res_hit_r) begin
      if (next_slot_r == nat_pkg::idx_t'(nat_pkg::ENTRIES - 1)) begin
        next_slot_nxt = '0;
      end else begin
        next_slot_nxt = next_slot_r + nat_pkg::idx_t'(1);
      end
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (fin_go) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nat_pkg::ST_IDLE;
      start_r     <= 1'b0;
      next_slot_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      start_r     <= in_acc;
      next_slot_r <= next_slot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // hold the request while it is in work
  always_ff @(posedge clk) begin
    if (in_acc) begin
      key_r  <= nat_pkg::trim_key(in_name_low, in_name_high);
      mode_r <= in_mode;
      tid_r  <= nat_pkg::id_t'(in_task_id);
    end
  end

  // capture the token leaving the last cell
  always_ff @(posedge clk) begin
    if (tok[nat_pkg::ENTRIES].act) begin
      res_hit_r <= tok[nat_pkg::ENTRIES].hit;
      res_idx_r <= tok[nat_pkg::ENTRIES].idx;
      res_id_r  <= tok[nat_pkg::ENTRIES].id;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      out_found_r    <= res_hit_r;
      out_found_id_r <= (mode_r == nat_pkg::MODE_LOOKUP && res_hit_r)
                        ? nat_pkg::tid_t'(res_id_r) : '0;
    end
  end

  // cell row
  assign tok[0] = '{act: start_r, hit: 1'b0, idx: '0, id: '0};

  for (genvar i = 0; i < nat_pkg::ENTRIES; i++) begin : g_cell
    assign wr_sel[i] = do_reg && (wr_tgt == nat_pkg::idx_t'(i));

    nat_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .my_idx (nat_pkg::idx_t'(i)),
      .key_i  (key_r),
      .tok_i  (tok[i]),
      .tok_o  (tok[i+1]),
      .wr_sel (wr_sel[i]),
      .wr_i   (wr)
    );
  end

  assign out_valid    = out_valid_r;
  assign out_found    = out_found_r;
  assign out_found_id = out_found_id_r;

endmodule

### src/nat_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nat_check: port-level checks for the name-to-id table
// Watches request spacing and result behavior; attached by bind.
// ----------------------------------------------------------------------------
module nat_check (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_found,
  input logic [7:0]  out_found_id
);

  // a request keeps the table busy once it is taken
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall ##1 in_stall)
    else $error("table took a request while the previous one was in work");

  // a miss never reports an id
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_found_id == 8'h00))
    else $error("nonzero id on a miss");

  // a stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_found) && $stable(out_found_id)))
    else $error("stalled result changed");

  // a fresh result appears only while no request is in work
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !in_stall)
    else $error("result appeared while a request was still in work");

endmodule

bind name_to_id_assoc_table nat_check u_nat_check (.*);

### sim/tb_name_to_id_assoc_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_name_to_id_assoc_table: self-checking bench for the name-to-id table
// Walks a directed table of register and lookup requests, then random
// traffic drawn mostly from a changing pool of names. Every accepted
// request is run through a local table model and each returned result is
// compared in order against the model or a directed row's typed result,
// with random gaps on the request side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb_name_to_id_assoc_table;

  localparam int RANDOM_REQUESTS = 1780;
  localparam int PHASE_LEN       = 120;
  localparam int POOL_MAX        = 40;
  localparam int IDLE_LIMIT      = 2000;
  localparam int DRAIN_CYCLES    = 40;
  localparam int SHOW_LIMIT      = 10;

  typedef struct {
    logic        found;
    logic [7:0]  id;
  } reply_t;

  typedef struct {
    logic        mode;
    logic [63:0] lo;
    logic [23:0] hi;
    logic [7:0]  tid;
    bit          typed;
    logic        found;
    logic [7:0]  id;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_mode;
  logic [63:0] in_name_low;
  logic [23:0] in_name_high;
  logic [7:0]  in_task_id;
  logic        out_valid;
  logic        out_stall;
  logic        out_found;
  logic [7:0]  out_found_id;

  // local copy of the table contents
  logic [87:0]  key_tbl [nat_pkg::ENTRIES];
  nat_pkg::id_t id_tbl  [nat_pkg::ENTRIES];
  bit           used_tbl[nat_pkg::ENTRIES];
  int unsigned  fill_ptr;

  reply_t      reply_q[$];
  reply_t      head_reply;
  int unsigned fail_count;
  int unsigned idle_cycles;
  int unsigned stall_left;
  int unsigned stall_draw;
  bit          quiet;

  stim_row_t   dir_rows[19];

  name_to_id_assoc_table uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_mode      (in_mode),
    .in_name_low  (in_name_low),
    .in_name_high (in_name_high),
    .in_task_id   (in_task_id),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_found    (out_found),
    .out_found_id (out_found_id)
  );

  always #1 clk = ~clk;

  // Cut the name at its first zero byte.
  function automatic logic [87:0] terminate_name(logic [87:0] raw);
    logic [87:0] mask;
    int          z;
    z = 11;
    for (int b = 10; b >= 0; b--) begin
      if (raw[8*b +: 8] == 8'h00) z = b;
    end
    mask = (z == 11) ? '1 : ((88'd1 << (8 * z)) - 88'd1);
    return raw & mask;
  endfunction

  // Search the local table, apply the request and return its result.
  function automatic reply_t predict_table(logic mode, logic [87:0] raw, logic [7:0] tid);
    reply_t      r;
    logic [87:0] key;
    int          hit;
    key = terminate_name(raw);
    hit = -1;
    for (int i = nat_pkg::ENTRIES - 1; i >= 0; i--) begin
      if (used_tbl[i] && key_tbl[i] == key) hit = i;
    end
    r.found = (hit >= 0);
    r.id    = 8'h00;
    if (mode == nat_pkg::MODE_REGISTER) begin
      if (hit >= 0) begin
        id_tbl[hit] = nat_pkg::id_t'(tid);
      end else begin
        key_tbl[fill_ptr]  = key;
        id_tbl[fill_ptr]   = nat_pkg::id_t'(tid);
        used_tbl[fill_ptr] = 1'b1;
        fill_ptr = (fill_ptr + 1) % nat_pkg::ENTRIES;
      end
    end else if (hit >= 0) begin
      r.id = 8'(id_tbl[hit]);
    end
    return r;
  endfunction

  // Build a name of len random nonzero bytes, zero padded.
  function automatic logic [87:0] fresh_name(int len);
    logic [87:0] n;
    n = '0;
    for (int b = 0; b < len; b++) n[8*b +: 8] = 8'($urandom_range(1, 255));
    return n;
  endfunction

  task automatic note_failure(string msg);
    fail_count++;
    if (fail_count <= SHOW_LIMIT) $display("MISMATCH: %s", msg);
  endtask

  // Offer one request, hold it until taken, then record its expected result.
  task automatic send_request(logic mode, logic [63:0] lo, logic [23:0] hi, logic [7:0] tid,
                              bit typed, reply_t typed_reply);
    int     gap;
    reply_t r;
    gap = quiet ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_mode      <= mode;
    in_name_low  <= lo;
    in_name_high <= hi;
    in_task_id   <= tid;
    do @(posedge clk); while (in_stall);
    r = predict_table(mode, {hi, lo}, tid);
    reply_q.push_back(typed ? typed_reply : r);
  endtask

  // Stall the result channel for a random count of valid cycles per result.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && !out_stall) begin
      stall_draw = quiet ? 0 : $urandom_range(0, 5);
      stall_left <= stall_draw;
      out_stall  <= (stall_draw != 0);
    end else if (out_valid && stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= (stall_left > 1);
    end
  end

  // Compare each returned result with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (reply_q.size() == 0) begin
        note_failure($sformatf("unexpected result found=%0b id=%02h",
                               out_found, out_found_id));
      end else begin
        head_reply = reply_q.pop_front();
        if (out_found !== head_reply.found)
          note_failure($sformatf("found exp %0b got %0b", head_reply.found, out_found));
        if (out_found_id !== head_reply.id)
          note_failure($sformatf("found_id exp %02h got %02h", head_reply.id, out_found_id));
      end
    end
  end

  // Abort when no request or result moves for too long.
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("name_to_id_assoc_table regression: fail");
        $finish;
      end
    end
  end

  initial begin
    logic [87:0] pool_key[POOL_MAX];
    int          pool_len[POOL_MAX];
    int          pool_size;
    int          k;
    int          sel;
    logic [87:0] raw;
    reply_t      typed_reply;

    clk          = 1'b0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_mode      = nat_pkg::MODE_REGISTER;
    in_name_low  = '0;
    in_name_high = '0;
    in_task_id   = '0;
    fail_count   = 0;
    quiet        = 1'b0;
    fill_ptr     = 0;
    for (int i = 0; i < nat_pkg::ENTRIES; i++) begin
      key_tbl[i]  = '0;
      id_tbl[i]   = '0;
      used_tbl[i] = 1'b0;
    end

    // empty, all-ones, short names, full 11-byte names, bytes past the end
    dir_rows = '{
      '{nat_pkg::MODE_LOOKUP,   64'h0, 24'h0, 8'h00, 1, 1'b0, 8'h00},
      '{nat_pkg::MODE_LOOKUP,   '1,    '1,    8'h00, 1, 1'b0, 8'h00},
      '{nat_pkg::MODE_REGISTER, '1,    '1,    8'hFF, 1, 1'b0, 8'h00},
      '{nat_pkg::MODE_LOOKUP,   '1,    '1,    8'h00, 1, 1'b1, 8'hFF},
      '{nat_pkg::MODE_REGISTER, 64'h0, 24'h0, 8'h00, 1, 1'b0, 8'h00},
      '{nat_pkg::MODE_LOOKUP,   64'hFFFF_FFFF_FFFF_FF00, 24'hFFFFFF, 8'h7F, 0, 1'b0, 8'h00},
      '{nat_pkg::MODE_REGISTER, 64'h41, 24'h0, 8'h5A, 0, 1'b0, 8'h00},
      '{nat_pkg::MODE_LOOKUP,   64'hA5A5_A5A5_A5A5_0041, 24'h123456, 8'h00, 0, 1'b0, 8'h00},
      '{nat_pkg::MODE_REGISTER, 64'h41, 24'h0, 8'h33, 0, 1'b0, 8'h00},
      '{nat_pkg::MODE_LOOKUP,   64'h41, 24'h0, 8'h00, 0, 1'b0, 8'h00},
      '{nat_pkg::MODE_REGISTER, 64'h0807_0605_0403_0201, 24'h0B0A09, 8'h80, 0, 1'b0, 8'h00},
      '{nat_pkg::MODE_LOOKUP,   64'h0807_0605_0403_0201, 24'h0B0009, 8'h00, 0, 1'b0, 8'h00},
      '{nat_pkg::MODE_LOOKUP,   64'h0807_0605_0403_0201, 24'h0B0A09, 8'h00, 0, 1'b0, 8'h00},
      '{nat_pkg::MODE_REGISTER, 64'h0807_0605_0403_0201, 24'h000009, 8'h01, 0, 1'b0, 8'h00},
      '{nat_pkg::MODE_LOOKUP,   64'h0807_0605_0403_0201, 24'hFF0009, 8'h00, 0, 1'b0, 8'h00},
      '{nat_pkg::MODE_LOOKUP,   64'h0807_0605_0403_0201, 24'h0B0A09, 8'hFF, 0, 1'b0, 8'h00},
      '{nat_pkg::MODE_LOOKUP,   '1,    '1,    8'h00, 0, 1'b0, 8'h00},
      '{nat_pkg::MODE_REGISTER, '1,    '1,    8'h00, 0, 1'b0, 8'h00},
      '{nat_pkg::MODE_LOOKUP,   '1,    '1,    8'hAA, 0, 1'b0, 8'h00}
    };

    for (int i = 0; i < POOL_MAX; i++) begin
      pool_len[i] = $urandom_range(0, 11);
      pool_key[i] = fresh_name(pool_len[i]);
    end
    pool_size = 20;

    // hold reset, then release it
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows
    foreach (dir_rows[i]) begin
      typed_reply.found = dir_rows[i].found;
      typed_reply.id    = dir_rows[i].id;
      send_request(dir_rows[i].mode, dir_rows[i].lo, dir_rows[i].hi, dir_rows[i].tid,
                   dir_rows[i].typed, typed_reply);
    end

    // random traffic in phases of pool size and idling
    typed_reply = '{1'b0, 8'h00};
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % PHASE_LEN == 0) begin
        quiet = ($urandom_range(0, 3) == 0);
        case ($urandom_range(0, 3))
          0: pool_size = 4;
          1: pool_size = 12;
          2: pool_size = 20;
          default: pool_size = POOL_MAX;
        endcase
        repeat (3) begin
          k = $urandom_range(0, POOL_MAX - 1);
          pool_len[k] = $urandom_range(0, 11);
          pool_key[k] = fresh_name(pool_len[k]);
        end
      end
      sel = $urandom_range(0, 99);
      if (sel < 15) begin
        raw = {24'($urandom()), 32'($urandom()), 32'($urandom())};
      end else begin
        k   = $urandom_range(0, pool_size - 1);
        raw = pool_key[k];
        // pad with junk after the terminating zero byte
        if (pool_len[k] < 10 && $urandom_range(0, 2) == 0) begin
          for (int b = pool_len[k] + 1; b < 11; b++) raw[8*b +: 8] = 8'($urandom_range(0, 255));
        end
      end
      send_request(1'($urandom_range(0, 1)), raw[63:0], raw[87:64],
                   8'($urandom_range(0, 255)), 0, typed_reply);
    end
    in_valid <= 1'b0;

    // drain outstanding results
    wait (reply_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("name_to_id_assoc_table regression: pass");
    end else begin
      $display("name_to_id_assoc_table regression: fail");
    end
    $finish;
  end

endmodule
